// ===== hdl/rgtp_pkg.sv =====
package rgtp_pkg;

    // Field widths fixed by the pixel stream format
    localparam int PIX_W      = 8;
    localparam int COORD_W    = 12;
    localparam int FRAME_W    = 13;
    localparam int RECIP_W    = 32;
    localparam int COEF_W     = 10;
    localparam int THR_W      = 8;
    localparam int CFG_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    // Internal arithmetic widths
    localparam int SQ_W     = 2 * COORD_W;           // one squared offset
    localparam int D2_W     = SQ_W + 1;              // sum of two squares
    localparam int HALF_W   = RECIP_W / 2;           // recip split point
    localparam int PROD_W   = D2_W + HALF_W;         // d2 times half recip
    localparam int R_W      = 16;                    // Q0.16 radius
    localparam int GCR_W    = R_W + COEF_W;          // coef times r
    localparam int SR_W     = R_W + THR_W;           // slope times r
    localparam int PG_W     = PIX_W + GCR_W;         // pixel times coef times r
    localparam int GAIN_SH  = 24;                    // gain fraction bits
    localparam int PGH_W    = PG_W - GAIN_SH;        // integer part of pg
    localparam int THRS_W   = THR_W + R_W + 1;       // scaled threshold
    localparam int PSUM_W   = PGH_W + 1;             // pixel plus pg integer

    // Register reset values
    localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST  = 13'd1920;
    localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST = 13'd1080;
    localparam logic [RECIP_W-1:0] RECIP_RST        = 32'hFFFF_FFFF;
    localparam logic [COEF_W-1:0]  GAIN_COEF_RST    = 10'd384;
    localparam logic [THR_W-1:0]   THRESH_BASE_RST  = 8'd55;
    localparam logic [THR_W-1:0]   THRESH_SLOPE_RST = 8'd25;

    // Register indexes on the configuration port
    typedef enum logic [REG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_RECIP        = 3'd2,
        REG_GAIN_COEF    = 3'd3,
        REG_THRESH_BASE  = 3'd4,
        REG_THRESH_SLOPE = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_width;
        logic [FRAME_W-1:0] frame_height;
        logic [RECIP_W-1:0] radius_norm_recip;
        logic [COEF_W-1:0]  gain_coef;
        logic [THR_W-1:0]   thresh_base;
        logic [THR_W-1:0]   thresh_slope;
    } cfg_t;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel_in;
        logic [COORD_W-1:0] row_index;
        logic [COORD_W-1:0] col_index;
    } in_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             was_zeroed;
    } out_t;

    // Pixel and normalized radius handed from the radius pipe to the gain pipe
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [R_W-1:0]   r;
    } rad_t;

endpackage

// ===== hdl/rgtp_cfg.sv =====
module rgtp_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rgtp_pkg::REG_IDX_W-1:0]      cfg_addr,
    input  logic [rgtp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output rgtp_pkg::cfg_t                      cfg
);

    rgtp_pkg::cfg_t cfg_reg;
    rgtp_pkg::cfg_t cfg_next;

    // Decode the write; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                rgtp_pkg::REG_FRAME_WIDTH:
                    cfg_next.frame_width = cfg_wdata[rgtp_pkg::FRAME_W-1:0];
                rgtp_pkg::REG_FRAME_HEIGHT:
                    cfg_next.frame_height = cfg_wdata[rgtp_pkg::FRAME_W-1:0];
                rgtp_pkg::REG_RECIP:
                    cfg_next.radius_norm_recip = cfg_wdata[rgtp_pkg::RECIP_W-1:0];
                rgtp_pkg::REG_GAIN_COEF:
                    cfg_next.gain_coef = cfg_wdata[rgtp_pkg::COEF_W-1:0];
                rgtp_pkg::REG_THRESH_BASE:
                    cfg_next.thresh_base = cfg_wdata[rgtp_pkg::THR_W-1:0];
                rgtp_pkg::REG_THRESH_SLOPE:
                    cfg_next.thresh_slope = cfg_wdata[rgtp_pkg::THR_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width       <= rgtp_pkg::FRAME_WIDTH_RST;
            cfg_reg.frame_height      <= rgtp_pkg::FRAME_HEIGHT_RST;
            cfg_reg.radius_norm_recip <= rgtp_pkg::RECIP_RST;
            cfg_reg.gain_coef         <= rgtp_pkg::GAIN_COEF_RST;
            cfg_reg.thresh_base       <= rgtp_pkg::THRESH_BASE_RST;
            cfg_reg.thresh_slope      <= rgtp_pkg::THRESH_SLOPE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/rgtp_radius.sv =====
module rgtp_radius #(
    parameter int COORD_BITS = 12
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  rgtp_pkg::in_t   in_data,
    input  rgtp_pkg::cfg_t  cfg,
    output logic            out_valid,
    output rgtp_pkg::rad_t  out_data
);

    localparam int CW = rgtp_pkg::COORD_W;
    // Coordinate bits taken from the fields
    localparam int UB = (COORD_BITS < CW) ? COORD_BITS : CW;
    localparam int NSTG = 5;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;

    // Stage 1: absolute offsets from the centre
    logic [rgtp_pkg::PIX_W-1:0] pix1_reg, pix1_next;
    logic [CW-1:0]              dr_reg, dr_next;
    logic [CW-1:0]              dc_reg, dc_next;
    logic [CW-1:0]              row_u, col_u, cx, cy;

    // Stage 2: squared offsets
    logic [rgtp_pkg::PIX_W-1:0] pix2_reg, pix2_next;
    logic [rgtp_pkg::SQ_W-1:0]  dr2_reg, dr2_next;
    logic [rgtp_pkg::SQ_W-1:0]  dc2_reg, dc2_next;

    // Stage 3: squared distance
    logic [rgtp_pkg::PIX_W-1:0] pix3_reg, pix3_next;
    logic [rgtp_pkg::D2_W-1:0]  d2_reg, d2_next;

    // Stage 4: partial products with the two reciprocal halves
    logic [rgtp_pkg::PIX_W-1:0]  pix4_reg, pix4_next;
    logic [rgtp_pkg::PROD_W-1:0] ph_reg, ph_next;
    logic [rgtp_pkg::PROD_W-1:0] pl_full;
    logic [rgtp_pkg::D2_W-1:0]   plh_reg, plh_next;

    // Stage 5: normalized radius, saturated
    logic [rgtp_pkg::PIX_W-1:0]  pix5_reg, pix5_next;
    logic [rgtp_pkg::R_W-1:0]    r_reg, r_next;
    logic [rgtp_pkg::PROD_W:0]   rsum;

    always_comb
    begin
        cx    = cfg.frame_width[rgtp_pkg::FRAME_W-1:1];
        cy    = cfg.frame_height[rgtp_pkg::FRAME_W-1:1];
        row_u = CW'(in_data.row_index[UB-1:0]);
        col_u = CW'(in_data.col_index[UB-1:0]);

        vld_next  = {vld_reg[NSTG-2:0], in_valid};

        pix1_next = in_data.pixel_in;
        dr_next   = (row_u >= cy) ? (row_u - cy) : (cy - row_u);
        dc_next   = (col_u >= cx) ? (col_u - cx) : (cx - col_u);

        pix2_next = pix1_reg;
        dr2_next  = rgtp_pkg::SQ_W'(dr_reg) * rgtp_pkg::SQ_W'(dr_reg);
        dc2_next  = rgtp_pkg::SQ_W'(dc_reg) * rgtp_pkg::SQ_W'(dc_reg);

        pix3_next = pix2_reg;
        d2_next   = rgtp_pkg::D2_W'(dr2_reg) + rgtp_pkg::D2_W'(dc2_reg);

        pix4_next = pix3_reg;
        ph_next   = rgtp_pkg::PROD_W'(d2_reg)
                  * rgtp_pkg::PROD_W'(cfg.radius_norm_recip[rgtp_pkg::RECIP_W-1:
                                                             rgtp_pkg::HALF_W]);
        pl_full   = rgtp_pkg::PROD_W'(d2_reg)
                  * rgtp_pkg::PROD_W'(cfg.radius_norm_recip[rgtp_pkg::HALF_W-1:0]);
        plh_next  = pl_full[rgtp_pkg::PROD_W-1:rgtp_pkg::HALF_W];

        pix5_next = pix4_reg;
        rsum      = (rgtp_pkg::PROD_W+1)'(ph_reg) + (rgtp_pkg::PROD_W+1)'(plh_reg);
        // Saturate just under one
        if (|rsum[rgtp_pkg::PROD_W:rgtp_pkg::R_W])
            r_next = {rgtp_pkg::R_W{1'b1}};
        else
            r_next = rsum[rgtp_pkg::R_W-1:0];
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pix1_reg <= pix1_next;
            dr_reg   <= dr_next;
            dc_reg   <= dc_next;
            pix2_reg <= pix2_next;
            dr2_reg  <= dr2_next;
            dc2_reg  <= dc2_next;
            pix3_reg <= pix3_next;
            d2_reg   <= d2_next;
            pix4_reg <= pix4_next;
            ph_reg   <= ph_next;
            plh_reg  <= plh_next;
            pix5_reg <= pix5_next;
            r_reg    <= r_next;
        end
    end

    assign out_valid      = vld_reg[NSTG-1];
    assign out_data.pix   = pix5_reg;
    assign out_data.r     = r_reg;

endmodule

// ===== hdl/rgtp_gain.sv =====
module rgtp_gain (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  rgtp_pkg::rad_t  in_data,
    input  rgtp_pkg::cfg_t  cfg,
    output logic            out_valid,
    output rgtp_pkg::out_t  out_data
);

    localparam int NSTG = 3;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;

    // Stage 6: coefficient and slope products
    logic [rgtp_pkg::PIX_W-1:0]  pix6_reg, pix6_next;
    logic [rgtp_pkg::GCR_W-1:0]  gcr_reg, gcr_next;
    logic [rgtp_pkg::SR_W-1:0]   sr_reg, sr_next;

    // Stage 7: pixel times radial term, scaled threshold
    logic [rgtp_pkg::PIX_W-1:0]  pix7_reg, pix7_next;
    logic [rgtp_pkg::PG_W-1:0]   pg_full;
    logic [rgtp_pkg::PGH_W-1:0]  pgh_reg, pgh_next;
    logic [rgtp_pkg::THRS_W-1:0] thr_reg, thr_next;

    // Stage 8: clamp, compare and output register
    logic [rgtp_pkg::PSUM_W-1:0] psum;
    logic [rgtp_pkg::PIX_W-1:0]  pclamp;
    logic                        zero;
    rgtp_pkg::out_t              res_reg, res_next;

    always_comb
    begin
        vld_next  = {vld_reg[NSTG-2:0], in_valid};

        pix6_next = in_data.pix;
        gcr_next  = rgtp_pkg::GCR_W'(in_data.r) * rgtp_pkg::GCR_W'(cfg.gain_coef);
        sr_next   = rgtp_pkg::SR_W'(in_data.r) * rgtp_pkg::SR_W'(cfg.thresh_slope);

        // pix * (1 + coef*r) splits into pix plus the scaled radial product
        pix7_next = pix6_reg;
        pg_full   = rgtp_pkg::PG_W'(pix6_reg) * rgtp_pkg::PG_W'(gcr_reg);
        pgh_next  = pg_full[rgtp_pkg::PG_W-1:rgtp_pkg::GAIN_SH];
        thr_next  = rgtp_pkg::THRS_W'({cfg.thresh_base, {rgtp_pkg::R_W{1'b0}}})
                  + rgtp_pkg::THRS_W'(sr_reg);

        psum = rgtp_pkg::PSUM_W'(pix7_reg) + rgtp_pkg::PSUM_W'(pgh_reg);
        if (|psum[rgtp_pkg::PSUM_W-1:rgtp_pkg::PIX_W])
            pclamp = {rgtp_pkg::PIX_W{1'b1}};
        else
            pclamp = psum[rgtp_pkg::PIX_W-1:0];
        zero = rgtp_pkg::THRS_W'({pclamp, {rgtp_pkg::R_W{1'b0}}}) < thr_reg;

        res_next.pixel_out  = zero ? '0 : pclamp;
        res_next.was_zeroed = zero;
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pix6_reg <= pix6_next;
            gcr_reg  <= gcr_next;
            sr_reg   <= sr_next;
            pix7_reg <= pix7_next;
            pgh_reg  <= pgh_next;
            thr_reg  <= thr_next;
            res_reg  <= res_next;
        end
    end

    assign out_valid = vld_reg[NSTG-1];
    assign out_data  = res_reg;

endmodule

// ===== hdl/radial_gain_threshold_pixel_top.sv =====
// Radial gain and threshold for a pixel stream (vignetting correction).
//
// pix_valid/pix_ready/pix_data carry one 8-bit sample with its row and
// column; res_valid/res_ready/res_data return the corrected sample and a
// flag set when the radial threshold forced it to zero. Every input
// transaction yields exactly one result transaction, in order.
//
// Eight register stages: an accepted transaction passes through all of them
// and leaves from the last as a result. Five stages form the normalized
// radius (offsets, squares, sum, recip partial products, saturating add)
// and three apply gain and threshold, the last being the output register.
// Throughput is one pixel per clock while the receiver does not stall.
//
// When the receiver stalls with a result waiting, every stage holds and
// pix_ready drops until the result is taken; nothing is lost or repeated.
// Reset clears all valid bits and loads the register defaults.
// Write registers through cfg_we/cfg_addr/cfg_wdata only while the pipe
// is empty; writes to unknown indexes are dropped.
module radial_gain_threshold_pixel_top #(
    parameter int COORD_BITS = 12
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             pix_valid,
    output logic                             pix_ready,
    input  rgtp_pkg::in_t                    pix_data,
    output logic                             res_valid,
    input  logic                             res_ready,
    output rgtp_pkg::out_t                   res_data,
    input  logic                             cfg_we,
    input  logic [rgtp_pkg::REG_IDX_W-1:0]   cfg_addr,
    input  logic [rgtp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    rgtp_pkg::cfg_t cfg;
    rgtp_pkg::rad_t rad_data;
    logic           rad_valid;
    logic           en;

    // Advance the pipe unless a finished result is held by the receiver
    assign en        = !res_valid || res_ready;
    assign pix_ready = en;

    rgtp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rgtp_radius #(
        .COORD_BITS (COORD_BITS)
    ) u_radius (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pix_valid),
        .in_data   (pix_data),
        .cfg       (cfg),
        .out_valid (rad_valid),
        .out_data  (rad_data)
    );

    rgtp_gain u_gain (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rad_valid),
        .in_data   (rad_data),
        .cfg       (cfg),
        .out_valid (res_valid),
        .out_data  (res_data)
    );

`ifndef ASSERT_OFF
    // A zeroed result carries a zero sample
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.was_zeroed |-> res_data.pixel_out == '0)
    else $error("zeroed result with nonzero sample");

    // The pipe only refuses input while a result is waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        !pix_ready |-> res_valid && !res_ready)
    else $error("input refused without a stalled result");

    // A zero threshold never zeroes a sample
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && cfg.thresh_base == '0 && cfg.thresh_slope == '0
        |-> !res_data.was_zeroed)
    else $error("sample zeroed under a zero threshold");

    // A result that is not taken stays held
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
    else $error("held result dropped");
`endif

endmodule
